// File: design/asto_pkg.sv
package asto_pkg;

    // Number of subscript fields and bound registers.
    localparam int DIMS = 4;

    localparam int SUB_W    = 16;
    localparam int BOUND_W  = 12;
    localparam int EXT_W    = BOUND_W + 1;
    localparam int RANK_W   = 3;
    localparam int OFFSET_W = 48;
    localparam int DIM_W    = 2;

    // Extent used for a dimension whose bound register holds zero.
    localparam logic [EXT_W-1:0] DEFAULT_EXT = EXT_W'(11);

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_RANK    = 3'd0;
    localparam logic [2:0] REG_BOUND_0 = 3'd1;
    localparam logic [2:0] REG_BOUND_1 = 3'd2;
    localparam logic [2:0] REG_BOUND_2 = 3'd3;
    localparam logic [2:0] REG_BOUND_3 = 3'd4;

    typedef logic [EXT_W-1:0] t_ext;

    // What one lane hands to the merge stage.
    typedef struct packed {
        logic                fail;
        logic [OFFSET_W-1:0] term;
    } t_lane_res;

endpackage

// File: design/asto_lane.sv
module asto_lane
    import asto_pkg::*;
#(
    parameter int LANE = 0
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SUB_W-1:0]  i_sub,
    input  logic [RANK_W-1:0] i_rank,
    input  t_ext              i_ext [DIMS],
    output t_lane_res         o_res
);

    logic [OFFSET_W-1:0] r_val  [DIMS];
    logic                r_fail [DIMS];

    logic [BOUND_W-1:0]  bound;
    logic                active;

    // Bounds check and masking of the subscript.
    always_comb begin
        bound  = BOUND_W'(i_ext[LANE] - EXT_W'(1));
        active = RANK_W'(LANE) < i_rank;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fail[0] <= active && (i_sub > SUB_W'(bound));
            r_val[0]  <= active ? OFFSET_W'(i_sub[BOUND_W-1:0]) : '0;
        end
    end

    // One multiply per stage by the extent of each later dimension in use.
    for (genvar k = 1; k < DIMS; k++) begin : g_stage
        logic [EXT_W-1:0]          mul;
        logic [OFFSET_W+EXT_W-1:0] prod;

        always_comb begin
            mul  = ((k > LANE) && (RANK_W'(k) < i_rank)) ? i_ext[k] : EXT_W'(1);
            prod = (OFFSET_W+EXT_W)'(r_val[k-1]) * (OFFSET_W+EXT_W)'(mul);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_val[k]  <= prod[OFFSET_W-1:0];
                r_fail[k] <= r_fail[k-1];
            end
        end
    end

    assign o_res.fail = r_fail[DIMS-1];
    assign o_res.term = r_val[DIMS-1];

endmodule

// File: design/asto_merge.sv
module asto_merge
    import asto_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_en,
    input  t_lane_res           i_res [DIMS],
    output logic [OFFSET_W-1:0] o_offset,
    output logic                o_oob,
    output logic [DIM_W-1:0]    o_bad_dim
);

    logic [OFFSET_W-1:0] r_sum_lo;
    logic [OFFSET_W-1:0] r_sum_hi;
    logic                r_fail;
    logic [DIM_W-1:0]    r_bad;
    logic [OFFSET_W-1:0] r_offset;
    logic                r_oob;
    logic [DIM_W-1:0]    r_bad_dim;

    logic                fail_any;
    logic [DIM_W-1:0]    first_bad;

    // The lowest failing dimension wins.
    always_comb begin
        fail_any  = 1'b0;
        first_bad = '0;
        for (int d = DIMS - 1; d >= 0; d--) begin
            if (i_res[d].fail) begin
                fail_any  = 1'b1;
                first_bad = DIM_W'(d);
            end
        end
    end

    // First level of the adder tree, plus the error summary.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum_lo <= i_res[0].term + i_res[1].term;
            r_sum_hi <= i_res[2].term + i_res[3].term;
            r_fail   <= fail_any;
            r_bad    <= first_bad;
        end
    end

    // Final sum; an out-of-bounds access reports offset zero.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_offset  <= r_fail ? '0 : r_sum_lo + r_sum_hi;
            r_oob     <= r_fail;
            r_bad_dim <= r_fail ? r_bad : '0;
        end
    end

    assign o_offset  = r_offset;
    assign o_oob     = r_oob;
    assign o_bad_dim = r_bad_dim;

endmodule

// File: design/array_subscript_to_offset.sv
// Row-major offset generator: each transfer on the input stream carries up to four
// subscripts, and each output transfer gives the element offset, an out-of-bounds
// flag and the first failing dimension. One access is taken every clock cycle unless
// the output stalls. One stage checks the bounds, three stages of per-dimension
// multipliers scale each subscript by the later extents, and a two-stage adder tree
// sums the lanes. Stalls on the output freeze the whole pipeline. Rank and bounds
// must be written over the APB port only while no access is in flight; the block
// does not enforce this itself. A bound of zero stands for ten.
module array_subscript_to_offset
    import asto_pkg::*;
#(
    parameter int MAX_RANK = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // sub_0 [15:0], sub_1 [31:16], sub_2 [47:32], sub_3 [63:48]
    input  logic [DIMS*SUB_W-1:0] i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // elem_offset [47:0]
    output logic [OFFSET_W-1:0]   o_m_tdata,
    // out_of_bounds [0], bad_dimension [2:1]
    output logic [DIM_W:0]        o_m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int RANK_LIMIT = (MAX_RANK < DIMS) ? MAX_RANK : DIMS;
    localparam logic [RANK_W-1:0] RANK_CAP = RANK_W'(RANK_LIMIT);
    localparam int LAT = DIMS + 2;

    logic [RANK_W-1:0]  r_rank;
    logic [BOUND_W-1:0] r_bound [DIMS];
    logic [LAT-1:0]     r_vld;

    logic               en;
    logic               wr_en;
    logic [2:0]         reg_idx;
    logic [RANK_W-1:0]  rank_eff;
    t_ext               ext [DIMS];
    t_lane_res          lane_res [DIMS];
    logic [OFFSET_W-1:0] offset;
    logic               oob;
    logic [DIM_W-1:0]   bad_dim;

    // Configuration registers.
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= RANK_W'(1);
            for (int d = 0; d < DIMS; d++) begin
                r_bound[d] <= '0;
            end
        end else if (wr_en) begin
            case (reg_idx)
                REG_RANK:    r_rank     <= pwdata[RANK_W-1:0];
                REG_BOUND_0: r_bound[0] <= pwdata[BOUND_W-1:0];
                REG_BOUND_1: r_bound[1] <= pwdata[BOUND_W-1:0];
                REG_BOUND_2: r_bound[2] <= pwdata[BOUND_W-1:0];
                REG_BOUND_3: r_bound[3] <= pwdata[BOUND_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RANK:    prdata = 32'(r_rank);
            REG_BOUND_0: prdata = 32'(r_bound[0]);
            REG_BOUND_1: prdata = 32'(r_bound[1]);
            REG_BOUND_2: prdata = 32'(r_bound[2]);
            REG_BOUND_3: prdata = 32'(r_bound[3]);
            default:     prdata = '0;
        endcase
    end

    // Effective rank and per-dimension extents.
    assign rank_eff = (r_rank > RANK_CAP) ? RANK_CAP : r_rank;

    always_comb begin
        for (int d = 0; d < DIMS; d++) begin
            ext[d] = (r_bound[d] == '0) ? DEFAULT_EXT : EXT_W'(r_bound[d]) + EXT_W'(1);
        end
    end

    // Pipeline advances whenever the output register is free or being taken.
    assign en         = !r_vld[LAT-1] || i_m_tready;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_tvalid};
        end
    end

    // One lane per dimension.
    for (genvar d = 0; d < DIMS; d++) begin : g_lane
        asto_lane #(
            .LANE (d)
        ) u_lane (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_sub  (i_s_tdata[d*SUB_W +: SUB_W]),
            .i_rank (rank_eff),
            .i_ext  (ext),
            .o_res  (lane_res[d])
        );
    end

    asto_merge u_merge (
        .i_clk     (i_clk),
        .i_en      (en),
        .i_res     (lane_res),
        .o_offset  (offset),
        .o_oob     (oob),
        .o_bad_dim (bad_dim)
    );

    assign o_m_tvalid = r_vld[LAT-1];
    assign o_m_tdata  = offset;
    assign o_m_tuser  = {bad_dim, oob};

endmodule
